### hdl/tcp_option_parser_top_macros.svh
// assertion macros used by the port-level checker file
`ifndef TCP_OPTION_PARSER_TOP_MACROS_SVH
`define TCP_OPTION_PARSER_TOP_MACROS_SVH

// clocked assertion, quiet while reset is applied
`define TOPT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("tcp option parser check failed");

// clocked assertion that also holds during reset
`define TOPT_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("tcp option parser check failed");

`endif

### hdl/tcp_opt_pkg.sv
// types, constants and reset values for the tcp option parser
package tcp_opt_pkg;

  localparam int unsigned MaxOptionBytes = 40;
  localparam int unsigned CountW = 6;

  localparam logic [7:0] KindEol  = 8'd0;
  localparam logic [7:0] KindNop  = 8'd1;
  localparam logic [7:0] KindMss  = 8'd2;
  localparam logic [7:0] KindWs   = 8'd3;
  localparam logic [7:0] KindSack = 8'd4;
  localparam logic [7:0] KindTs   = 8'd8;

  typedef enum logic [3:0] {
    PH_KIND = 4'b0001,
    PH_LEN  = 4'b0010,
    PH_BODY = 4'b0100,
    PH_STOP = 4'b1000
  } phase_e;

  typedef struct packed {
    phase_e             phase;
    logic [7:0]         kind;
    logic [7:0]         opt_len;
    logic [7:0]         body_idx;
    logic [15:0]        mss;
    logic [7:0]         shift;
    logic               sack;
    logic [31:0]        tsval;
    logic [31:0]        tsecr;
    logic [CountW-1:0]  count;
    logic               bad;
  } parse_state_t;

  // packed msb first, so mss_value lands in the low bits of the word
  typedef struct packed {
    logic               malformed;
    logic [CountW-1:0]  option_bytes;
    logic [31:0]        stamp_echo;
    logic [31:0]        stamp_value;
    logic               sack_permitted;
    logic [7:0]         window_shift;
    logic [15:0]        mss_value;
  } result_t;

  localparam int unsigned ResultW = $bits(result_t);

  localparam parse_state_t StateReset = '{
    phase:    PH_KIND,
    kind:     8'd0,
    opt_len:  8'd0,
    body_idx: 8'd0,
    mss:      16'd0,
    shift:    8'd0,
    sack:     1'b0,
    tsval:    32'd0,
    tsecr:    32'd0,
    count:    '0,
    bad:      1'b0
  };

endpackage

### hdl/tcp_opt_step.sv
// one-byte parse step: next parse state and result fields
module tcp_opt_step (
  input  tcp_opt_pkg::parse_state_t state_i,
  input  logic [7:0]                byte_i,
  input  logic                      first_i,
  output tcp_opt_pkg::parse_state_t state_o,
  output tcp_opt_pkg::result_t      result_o
);
  import tcp_opt_pkg::*;

  parse_state_t cur;
  parse_state_t nxt;
  logic [8:0]   idx_inc;

  always_comb begin
    cur = first_i ? StateReset : state_i;
    nxt = cur;
    idx_inc = {1'b0, cur.body_idx} + 9'd1;

    if (cur.count < CountW'(MaxOptionBytes)) begin
      nxt.count = cur.count + CountW'(1);
    end

    case (cur.phase)
      PH_KIND: begin
        nxt.kind = byte_i;
        if (byte_i == KindEol) begin
          nxt.phase = PH_STOP;
        end else if (byte_i != KindNop) begin
          nxt.phase = PH_LEN;
        end
      end
      PH_LEN: begin
        nxt.opt_len = byte_i;
        if (byte_i < 8'd2) begin
          nxt.bad   = 1'b1;
          nxt.phase = PH_STOP;
        end else begin
          if (cur.kind == KindSack) begin
            nxt.sack = 1'b1;
          end
          nxt.body_idx = 8'd2;
          nxt.phase    = (byte_i > 8'd2) ? PH_BODY : PH_KIND;
        end
      end
      PH_BODY: begin
        // field bytes are taken only when the length covers the whole field
        if (cur.kind == KindMss && cur.opt_len >= 8'd4 &&
            (cur.body_idx == 8'd2 || cur.body_idx == 8'd3)) begin
          nxt.mss = {cur.mss[7:0], byte_i};
        end else if (cur.kind == KindWs && cur.opt_len >= 8'd3 &&
                     cur.body_idx == 8'd2) begin
          nxt.shift = byte_i;
        end else if (cur.kind == KindTs && cur.opt_len >= 8'd10) begin
          if (cur.body_idx >= 8'd2 && cur.body_idx <= 8'd5) begin
            nxt.tsval = {cur.tsval[23:0], byte_i};
          end else if (cur.body_idx >= 8'd6 && cur.body_idx <= 8'd9) begin
            nxt.tsecr = {cur.tsecr[23:0], byte_i};
          end
        end
        nxt.body_idx = idx_inc[7:0];
        if (idx_inc >= {1'b0, cur.opt_len}) begin
          nxt.phase = PH_KIND;
        end
      end
      default: begin
      end
    endcase

    state_o = nxt;

    result_o.mss_value      = nxt.mss;
    result_o.window_shift   = nxt.shift;
    result_o.sack_permitted = nxt.sack;
    result_o.stamp_value    = nxt.tsval;
    result_o.stamp_echo     = nxt.tsecr;
    result_o.option_bytes   = nxt.count;
    // an option still open at the end of the area is cut off
    result_o.malformed      = nxt.bad | (nxt.phase == PH_LEN) | (nxt.phase == PH_BODY);
  end

endmodule

### hdl/tcp_opt_out.sv
// result register on the master side
module tcp_opt_out (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  tcp_opt_pkg::result_t result_i,
  input  logic                 ready_i,
  output logic                 valid_o,
  output tcp_opt_pkg::result_t data_o,
  output logic                 free_o
);
  import tcp_opt_pkg::*;

  logic    valid_q;
  result_t data_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

endmodule

### hdl/tcp_option_parser_top.sv
// top level of the tcp option parser: input register, parse state, result register
// the accepted last byte goes through the input register and then the result register to m_axis
// throughput: one options byte per cycle; a byte that closes the area waits
//   only while the result register is still full and not being taken
// reset: rst_ni low clears the input register valid, the parse state and the result valid
module tcp_option_parser_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [7:0]                   s_axis_tdata_i,  // [7:0] opt_byte
  input  logic                         s_axis_tlast_i,  // last_byte
  input  logic                         s_axis_tuser_i,  // first_byte
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // [15:0] mss_value, [23:16] window_shift, [24] sack_permitted,
  // [56:25] stamp_value, [88:57] stamp_echo, [94:89] option_bytes, [95] malformed
  output logic [tcp_opt_pkg::ResultW-1:0] m_axis_tdata_o
);
  import tcp_opt_pkg::*;

  // input register stage
  logic         in_valid_q;
  logic [7:0]   in_byte_q;
  logic         in_first_q;
  logic         in_last_q;

  // running parse state for the current options area
  parse_state_t state_q;
  parse_state_t state_d;

  result_t      step_res;
  result_t      out_data;
  logic         out_free;
  logic         advance;

  // a non-last byte never needs the result register, so it always moves on
  assign advance         = in_valid_q && (!in_last_q || out_free);
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q  <= s_axis_tdata_i;
      in_first_q <= s_axis_tuser_i;
      in_last_q  <= s_axis_tlast_i;
    end
  end

  tcp_opt_step u_step (
    .state_i  (state_q),
    .byte_i   (in_byte_q),
    .first_i  (in_first_q),
    .state_o  (state_d),
    .result_o (step_res)
  );

  // the area closes on the last word: state goes back to its reset value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateReset;
    end else if (advance) begin
      state_q <= in_last_q ? StateReset : state_d;
    end
  end

  tcp_opt_out u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (advance && in_last_q),
    .result_i (step_res),
    .ready_i  (m_axis_tready_i),
    .valid_o  (m_axis_tvalid_o),
    .data_o   (out_data),
    .free_o   (out_free)
  );

  assign m_axis_tdata_o = out_data;

endmodule

### hdl/tcp_opt_chk.sv
// port-level checker for the tcp option parser, bound to the top level
`include "tcp_option_parser_top_macros.svh"

module tcp_opt_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_tvalid_i,
  input logic                          s_tready_i,
  input logic                          m_tvalid_i,
  input logic                          m_tready_i,
  input logic [tcp_opt_pkg::ResultW-1:0] m_tdata_i
);
  import tcp_opt_pkg::*;

  logic [CountW-1:0] seen_bytes;
  logic              one_byte_area;
  logic              count_ok;

  assign seen_bytes    = m_tdata_i[94:89];
  assign one_byte_area = (seen_bytes == CountW'(1));
  assign count_ok      = (seen_bytes != '0) && (seen_bytes <= CountW'(MaxOptionBytes));

  // a stalled result word holds
  `TOPT_ASSERT(a_out_hold, m_tvalid_i && !m_tready_i |=> m_tvalid_i && $stable(m_tdata_i))

  // byte count of a result lies between one and the saturation limit
  `TOPT_ASSERT(a_count_range, m_tvalid_i |-> count_ok)

  // a single-byte area can capture no option field
  `TOPT_ASSERT(a_one_byte_clean, m_tvalid_i && one_byte_area |-> m_tdata_i[88:0] == '0)

  // no result word in the cycle after reset is seen low
  `TOPT_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !m_tvalid_i)

  logic unused_s;
  assign unused_s = s_tvalid_i & s_tready_i;

endmodule

bind tcp_option_parser_top tcp_opt_chk u_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_axis_tvalid_i),
  .s_tready_i (s_axis_tready_o),
  .m_tvalid_i (m_axis_tvalid_o),
  .m_tready_i (m_axis_tready_i),
  .m_tdata_i  (m_axis_tdata_o)
);
